// ----- design/pcswl_pkg.sv -----
package pcswl_pkg;

  localparam int unsigned MaxClients  = 64;
  localparam int unsigned MaxRequests = 16;
  localparam int unsigned SlotW       = $clog2(MaxClients);
  localparam int unsigned ReqIdxW     = $clog2(MaxRequests);

  // register indexes of the write port
  localparam logic [1:0] RegWindowLength = 2'd0;
  localparam logic [1:0] RegRequestLimit = 2'd1;
  localparam logic [1:0] RegClientLimit  = 2'd2;
  localparam logic [1:0] RegBlockEnable  = 2'd3;

  // verdict codes
  localparam logic [2:0] VerdAdmitted     = 3'd0;
  localparam logic [2:0] VerdTableFull    = 3'd1;
  localparam logic [2:0] VerdStillBlocked = 3'd2;
  localparam logic [2:0] VerdOverLimit    = 3'd3;
  localparam logic [2:0] VerdNowBlocked   = 3'd4;
  localparam logic [2:0] VerdCleanupDone  = 3'd5;

  localparam logic OpCheck   = 1'b0;
  localparam logic OpCleanup = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] verdict;
    logic [6:0] clients_tracked;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [4:0]  count;
    logic        blocked;
    logic [31:0] unblock_at;
  } entry_t;

  typedef struct packed {
    logic in_win;
    logic expired;
  } tu_flags_t;

endpackage

// ----- design/pcswl_time_unit.sv -----
module pcswl_time_unit import pcswl_pkg::*; (
  input  logic [31:0] now_i,
  input  logic [31:0] oper_i,
  input  logic [15:0] win_i,
  output tu_flags_t   flags_o
);

  logic [31:0] diff;

  // wrapping difference, shared by the window and block-expiry tests
  assign diff            = now_i - oper_i;
  assign flags_o.in_win  = diff < {16'd0, win_i};
  assign flags_o.expired = ~diff[31];

endmodule

// ----- design/per_client_sliding_window_limiter_unit.sv -----
// Per-client sliding-window rate limiter. A check transfer (op 0) looks up the
// client address in a table of up to 64 entries, allocating a cleared entry
// when it is new (or denying it when the table is at the client limit), lifts
// an expired block, drops logged times older than the window and then admits
// and logs the request or denies it, blocking the client for twice the window
// when blocking is enabled. A cleanup transfer (op 1) packs the table from
// slot 0, keeping clients that are still blocked or have a logged request
// inside the window. Drive start high with the item on req_i while busy is
// low; busy then stays high until the result appears (a cleanup of an empty
// table answers at once without raising busy). Each item gives one result on
// rsp_o, shown for exactly one cycle with done_o high; the receiver cannot
// stall it, so it must take it in that cycle. A new start is taken in the same
// cycle that done_o is high. The client search reads each entry from the entry
// memory in a read state and compares its key in a compare state, and the log
// scan reads and tests each logged time the same way; the result shows in the
// cycle after the last busy cycle. A cleanup reads each entry and its logged
// times the same way and copies the logged times of an entry that moves one by one.
// All time compares go through one shared subtractor. Write the configuration
// only while idle; writes are not held off while busy.
module per_client_sliding_window_limiter_unit import pcswl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [15:0] {
    StIdle   = 16'h0001,
    StSrd    = 16'h0002,
    StScmp   = 16'h0004,
    StMiss   = 16'h0008,
    StBlk    = 16'h0010,
    StTrd    = 16'h0020,
    StTcmp   = 16'h0040,
    StDec    = 16'h0080,
    StKrd    = 16'h0100,
    StKchk   = 16'h0200,
    StKtrd   = 16'h0400,
    StKtcmp  = 16'h0800,
    StKkeep  = 16'h1000,
    StKcrd   = 16'h2000,
    StKcwr   = 16'h4000,
    StKnext  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] wl_q;
  logic [4:0]  rl_q;
  logic [6:0]  cl_q;
  logic        be_q;

  // item and working registers
  req_t                item_q, item_d;
  entry_t              cur_q, cur_d;
  logic [6:0]          used_q, used_d;
  logic [6:0]          idx_q, idx_d;
  logic [6:0]          w_q, w_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [4:0]          i_q, i_d;
  logic [4:0]          v_q, v_d;
  logic [4:0]          n_q, n_d;

  // result register
  logic done_q, done_d;
  rsp_t rsp_q, rsp_d;

  // memories
  entry_t      client_mem [MaxClients];
  logic [31:0] times_mem  [MaxClients*MaxRequests];
  entry_t      ent_q;
  logic [31:0] tdata_q;

  logic                       cwe;
  logic [SlotW-1:0]           cwaddr, craddr;
  entry_t                     cwdata;
  logic                       twe;
  logic [SlotW+ReqIdxW-1:0]   twaddr, traddr;
  logic [31:0]                twdata;

  // shared time unit
  logic [31:0] tu_oper;
  tu_flags_t   tu_flags;

  logic [6:0] climit;
  logic [4:0] rlimit;
  logic [4:0] ncap;
  logic [4:0] ent_ncap;

  assign climit   = (cl_q > 7'(MaxClients)) ? 7'(MaxClients) : cl_q;
  assign rlimit   = (rl_q > 5'(MaxRequests)) ? 5'(MaxRequests) : rl_q;
  assign ncap     = (cur_q.count > 5'(MaxRequests)) ? 5'(MaxRequests) : cur_q.count;
  assign ent_ncap = (ent_q.count > 5'(MaxRequests)) ? 5'(MaxRequests) : ent_q.count;

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    unique case (state_q)
      StBlk:   tu_oper = cur_q.unblock_at;
      StKchk:  tu_oper = ent_q.unblock_at;
      default: tu_oper = tdata_q;
    endcase
  end

  pcswl_time_unit u_time (
    .now_i   (item_q.now_seconds),
    .oper_i  (tu_oper),
    .win_i   (wl_q),
    .flags_o (tu_flags)
  );

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= 16'd60;
      rl_q <= 5'd10;
      cl_q <= 7'd64;
      be_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWindowLength: wl_q <= cfg_data_i;
        RegRequestLimit: rl_q <= cfg_data_i[4:0];
        RegClientLimit:  cl_q <= cfg_data_i[6:0];
        RegBlockEnable:  be_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (cwe) begin
      client_mem[cwaddr] <= cwdata;
    end
    ent_q <= client_mem[craddr];
  end

  always_ff @(posedge clk_i) begin
    if (twe) begin
      times_mem[twaddr] <= twdata;
    end
    tdata_q <= times_mem[traddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    cur_d   = cur_q;
    used_d  = used_q;
    idx_d   = idx_q;
    w_d     = w_q;
    slot_d  = slot_q;
    i_d     = i_q;
    v_d     = v_q;
    n_d     = n_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    cwe     = 1'b0;
    cwaddr  = slot_q;
    cwdata  = cur_q;
    craddr  = idx_q[SlotW-1:0];
    twe     = 1'b0;
    twaddr  = {slot_q, v_q[ReqIdxW-1:0]};
    twdata  = tdata_q;
    traddr  = {slot_q, i_q[ReqIdxW-1:0]};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          item_d = req_i;
          idx_d  = 7'd0;
          w_d    = 7'd0;
          if (req_i.op == OpCleanup) begin
            if (used_q == 7'd0) begin
              done_d = 1'b1;
              rsp_d  = '{allowed: 1'b0, verdict: VerdCleanupDone, clients_tracked: 7'd0};
            end else begin
              state_d = StKrd;
            end
          end else begin
            state_d = (used_q == 7'd0) ? StMiss : StSrd;
          end
        end
      end

      // client search
      StSrd: begin
        state_d = StScmp;
      end
      StScmp: begin
        if (ent_q.key == item_q.client_addr) begin
          cur_d   = ent_q;
          slot_d  = idx_q[SlotW-1:0];
          state_d = StBlk;
        end else if (7'(idx_q + 7'd1) == used_q) begin
          state_d = StMiss;
        end else begin
          idx_d   = 7'(idx_q + 7'd1);
          state_d = StSrd;
        end
      end
      StMiss: begin
        if (used_q >= climit) begin
          done_d  = 1'b1;
          rsp_d   = '{allowed: 1'b0, verdict: VerdTableFull, clients_tracked: used_q};
          state_d = StIdle;
        end else begin
          slot_d  = used_q[SlotW-1:0];
          cur_d   = '{key: item_q.client_addr, count: 5'd0, blocked: 1'b0,
                      unblock_at: 32'd0};
          used_d  = 7'(used_q + 7'd1);
          state_d = StBlk;
        end
      end

      // block handling and log scan setup
      StBlk: begin
        i_d = 5'd0;
        v_d = 5'd0;
        if (cur_q.blocked && !tu_flags.expired) begin
          done_d  = 1'b1;
          rsp_d   = '{allowed: 1'b0, verdict: VerdStillBlocked, clients_tracked: used_q};
          state_d = StIdle;
        end else if (cur_q.blocked) begin
          cur_d.blocked = 1'b0;
          cur_d.count   = 5'd0;
          n_d           = 5'd0;
          state_d       = StDec;
        end else begin
          n_d     = ncap;
          state_d = (ncap == 5'd0) ? StDec : StTrd;
        end
      end

      // drop stale times, compacting in place
      StTrd: begin
        state_d = StTcmp;
      end
      StTcmp: begin
        if (tu_flags.in_win) begin
          twe = 1'b1;
          v_d = 5'(v_q + 5'd1);
        end
        if (5'(i_q + 5'd1) == n_q) begin
          state_d = StDec;
        end else begin
          i_d     = 5'(i_q + 5'd1);
          state_d = StTrd;
        end
      end

      StDec: begin
        cwe    = 1'b1;
        done_d = 1'b1;
        rsp_d.clients_tracked = used_q;
        if (v_q < rlimit) begin
          twe         = 1'b1;
          twdata      = item_q.now_seconds;
          cwdata.count = 5'(v_q + 5'd1);
          rsp_d.allowed = 1'b1;
          rsp_d.verdict = VerdAdmitted;
        end else if (be_q) begin
          cwdata.count      = v_q;
          cwdata.blocked    = 1'b1;
          cwdata.unblock_at = item_q.now_seconds + {15'd0, wl_q, 1'b0};
          rsp_d.allowed     = 1'b0;
          rsp_d.verdict     = VerdNowBlocked;
        end else begin
          cwdata.count  = v_q;
          rsp_d.allowed = 1'b0;
          rsp_d.verdict = VerdOverLimit;
        end
        state_d = StIdle;
      end

      // cleanup: examine entry at idx
      StKrd: begin
        state_d = StKchk;
      end
      StKchk: begin
        cur_d = ent_q;
        i_d   = 5'd0;
        n_d   = ent_ncap;
        if (ent_q.blocked && !tu_flags.expired) begin
          state_d = StKkeep;
        end else if (ent_ncap == 5'd0) begin
          state_d = StKnext;
        end else begin
          state_d = StKtrd;
        end
      end
      StKtrd: begin
        traddr  = {idx_q[SlotW-1:0], i_q[ReqIdxW-1:0]};
        state_d = StKtcmp;
      end
      StKtcmp: begin
        if (tu_flags.in_win) begin
          state_d = StKkeep;
        end else if (5'(i_q + 5'd1) == n_q) begin
          state_d = StKnext;
        end else begin
          i_d     = 5'(i_q + 5'd1);
          state_d = StKtrd;
        end
      end

      // kept entry: move down to slot w with its log
      StKkeep: begin
        cwe    = 1'b1;
        cwaddr = w_q[SlotW-1:0];
        i_d    = 5'd0;
        n_d    = ncap;
        if (w_q != idx_q && ncap != 5'd0) begin
          state_d = StKcrd;
        end else begin
          w_d     = 7'(w_q + 7'd1);
          state_d = StKnext;
        end
      end
      StKcrd: begin
        traddr  = {idx_q[SlotW-1:0], i_q[ReqIdxW-1:0]};
        state_d = StKcwr;
      end
      StKcwr: begin
        twe    = 1'b1;
        twaddr = {w_q[SlotW-1:0], i_q[ReqIdxW-1:0]};
        if (5'(i_q + 5'd1) == n_q) begin
          w_d     = 7'(w_q + 7'd1);
          state_d = StKnext;
        end else begin
          i_d     = 5'(i_q + 5'd1);
          state_d = StKcrd;
        end
      end
      StKnext: begin
        if (7'(idx_q + 7'd1) == used_q) begin
          used_d  = w_q;
          done_d  = 1'b1;
          rsp_d   = '{allowed: 1'b0, verdict: VerdCleanupDone, clients_tracked: w_q};
          state_d = StIdle;
        end else begin
          idx_d   = 7'(idx_q + 7'd1);
          state_d = StKrd;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q  <= 7'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    w_q    <= w_d;
    slot_q <= slot_d;
    i_q    <= i_d;
    v_q    <= v_d;
    n_q    <= n_d;
    rsp_q  <= rsp_d;
  end

endmodule

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
  import pcswl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // generous cycle budget for all tests
  localparam int unsigned CycleLimit = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  per_client_sliding_window_limiter_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the configuration, as last written
  logic [15:0] window_len;
  logic [4:0]  req_limit;
  logic [6:0]  client_cap;
  logic        block_on;

  // shadow copy of the client table
  int unsigned tracked_cnt;
  logic [31:0] slot_key     [MaxClients];
  int unsigned slot_cnt     [MaxClients];
  logic        slot_blocked [MaxClients];
  logic [31:0] slot_unblock [MaxClients];
  logic [31:0] slot_log     [MaxClients][MaxRequests];

  rsp_t        pending_rsp[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  logic [31:0] clock_now;

  // a logged time counts while it lies less than one window back, modulo 2^32
  function automatic bit in_window(logic [31:0] now, logic [31:0] t);
    logic [31:0] diff;
    diff = now - t;
    return diff < {16'd0, window_len};
  endfunction

  // a block is over once the wrapped signed difference is zero or positive
  function automatic bit block_over(logic [31:0] now, logic [31:0] unblock_at);
    logic [31:0] diff;
    diff = now - unblock_at;
    return !diff[31];
  endfunction

  // works out the verdict for one accepted transfer and updates the shadow table
  function automatic rsp_t predict_verdict(req_t r);
    int unsigned climit;
    int unsigned rlimit;
    int unsigned s;
    int unsigned n;
    int unsigned v;
    int unsigned w;
    bit          found;
    bit          keep;
    rsp_t        o;
    climit = (client_cap > MaxClients) ? MaxClients : client_cap;
    rlimit = (req_limit > MaxRequests) ? MaxRequests : req_limit;
    o.allowed = 1'b0;
    if (r.op == OpCleanup) begin
      // pack kept entries from slot 0 in their old order
      w = 0;
      for (int unsigned e = 0; e < tracked_cnt; e++) begin
        keep = slot_blocked[e] && !block_over(r.now_seconds, slot_unblock[e]);
        for (int unsigned i = 0; i < slot_cnt[e]; i++)
          if (in_window(r.now_seconds, slot_log[e][i])) keep = 1'b1;
        if (keep) begin
          slot_key[w]     = slot_key[e];
          slot_cnt[w]     = slot_cnt[e];
          slot_blocked[w] = slot_blocked[e];
          slot_unblock[w] = slot_unblock[e];
          for (int unsigned i = 0; i < MaxRequests; i++) slot_log[w][i] = slot_log[e][i];
          w++;
        end
      end
      tracked_cnt = w;
      o.verdict = VerdCleanupDone;
      o.clients_tracked = tracked_cnt[6:0];
      return o;
    end
    found = 1'b0;
    s = 0;
    for (int unsigned e = 0; e < tracked_cnt; e++)
      if (!found && slot_key[e] == r.client_addr) begin
        found = 1'b1;
        s = e;
      end
    if (!found) begin
      if (tracked_cnt >= climit) begin
        o.verdict = VerdTableFull;
        o.clients_tracked = tracked_cnt[6:0];
        return o;
      end
      // reused slot starts cleared
      s = tracked_cnt;
      slot_key[s]     = r.client_addr;
      slot_cnt[s]     = 0;
      slot_blocked[s] = 1'b0;
      slot_unblock[s] = '0;
      tracked_cnt++;
    end
    if (slot_blocked[s]) begin
      if (block_over(r.now_seconds, slot_unblock[s])) begin
        // lifting the block empties the log
        slot_blocked[s] = 1'b0;
        slot_cnt[s] = 0;
      end else begin
        o.verdict = VerdStillBlocked;
        o.clients_tracked = tracked_cnt[6:0];
        return o;
      end
    end
    n = slot_cnt[s];
    v = 0;
    for (int unsigned i = 0; i < n; i++)
      if (in_window(r.now_seconds, slot_log[s][i])) begin
        slot_log[s][v] = slot_log[s][i];
        v++;
      end
    slot_cnt[s] = v;
    if (v < rlimit) begin
      slot_log[s][v] = r.now_seconds;
      slot_cnt[s] = v + 1;
      o.allowed = 1'b1;
      o.verdict = VerdAdmitted;
    end else if (block_on) begin
      slot_blocked[s] = 1'b1;
      slot_unblock[s] = r.now_seconds + {15'd0, window_len, 1'b0};
      o.verdict = VerdNowBlocked;
    end else begin
      o.verdict = VerdOverLimit;
    end
    o.clients_tracked = tracked_cnt[6:0];
    return o;
  endfunction

  // result checker: every done pulse must match the oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transfer %p", rsp_o);
        err_cnt++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o.allowed !== exp_rsp.allowed) begin
          $error("allowed: expected %0d, got %0d", exp_rsp.allowed, rsp_o.allowed);
          err_cnt++;
        end
        if (rsp_o.verdict !== exp_rsp.verdict) begin
          $error("verdict: expected %0d, got %0d", exp_rsp.verdict, rsp_o.verdict);
          err_cnt++;
        end
        if (rsp_o.clients_tracked !== exp_rsp.clients_tracked) begin
          $error("clients_tracked: expected %0d, got %0d",
                 exp_rsp.clients_tracked, rsp_o.clients_tracked);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one request transfer; start stays high if no gap follows, so the next call
  // re-drives it without a second assignment in the same step
  task automatic issue_request(logic op, logic [31:0] addr, logic [31:0] now);
    req_t r;
    r.op = op;
    r.client_addr = addr;
    r.now_seconds = now;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsp.push_back(predict_verdict(r));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // writes all four registers, one per cycle, while the block is idle
  task automatic write_regs(logic [15:0] win, logic [15:0] rl, logic [15:0] cl,
                            logic [15:0] be);
    logic [15:0] vals [4];
    vals = '{win, rl, cl, be};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (2'(i))
        RegWindowLength: window_len = vals[i];
        RegRequestLimit: req_limit  = vals[i][4:0];
        RegClientLimit:  client_cap = vals[i][6:0];
        RegBlockEnable:  block_on   = vals[i][0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // reset values: burst past the limit, block, still blocked, expiry, wrap
  task automatic test_defaults();
    idle_pct = 0;
    for (int i = 0; i < 11; i++) issue_request(OpCheck, 32'h0a00_0001, 32'd1000 + 32'(i));
    issue_request(OpCheck, 32'h0a00_0001, 32'd1050);
    issue_request(OpCleanup, 32'hffff_ffff, 32'd1060);
    issue_request(OpCheck, 32'h0a00_0001, 32'd1130);
    issue_request(OpCheck, 32'h0000_0000, 32'hffff_fffe);
    issue_request(OpCheck, 32'hffff_ffff, 32'hffff_ffff);
    issue_request(OpCheck, 32'h0000_0000, 32'h0000_0005);
    issue_request(OpCleanup, 32'h0000_0000, 32'h0000_0010);
    issue_request(OpCleanup, 32'h1234_5678, 32'h8000_0000);
    drain_results();
  endtask

  // zero limits and window, blocking off, then values above the caps
  task automatic test_config_extremes();
    issue_request(OpCheck, 32'hc0a8_0101, 32'd50);
    drain_results();
    write_regs(16'd0, 16'd0, 16'd0, 16'd0);
    issue_request(OpCheck, 32'hc0a8_0101, 32'd60);
    issue_request(OpCheck, 32'hc0a8_0202, 32'd61);
    issue_request(OpCleanup, 32'd0, 32'd62);
    drain_results();
    write_regs(16'hffff, 16'd31, 16'd127, 16'd1);
    issue_request(OpCheck, 32'hc0a8_0303, 32'd70);
    issue_request(OpCheck, 32'hc0a8_0303, 32'd71);
    issue_request(OpCleanup, 32'd0, 32'd72);
    drain_results();
  endtask

  // one random phase: traffic from a pool of clients plus stray addresses
  task automatic test_random_phase(int unsigned win, int unsigned rl, int unsigned cl,
                                   int unsigned be, int unsigned idle, int unsigned pool_n,
                                   int unsigned items);
    logic [31:0] pool [$];
    logic [31:0] addr;
    logic        op;
    int unsigned step_max;
    write_regs(16'(win), 16'(rl), 16'(cl), 16'(be));
    idle_pct = idle;
    clock_now = $urandom();
    step_max = (win > 1000) ? 2000 : 2 * win + 2;
    for (int unsigned i = 0; i < pool_n; i++) pool.push_back($urandom());
    for (int unsigned i = 0; i < items; i++) begin
      op = ($urandom_range(0, 99) < 6) ? OpCleanup : OpCheck;
      addr = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)] : $urandom();
      case ($urandom_range(0, 19))
        0:         clock_now = $urandom();
        1, 2, 3:   clock_now += $urandom_range(0, step_max);
        4, 5, 6:   clock_now += win;
        default:   clock_now += $urandom_range(0, 2);
      endcase
      issue_request(op, addr, clock_now);
    end
    drain_results();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= RegWindowLength;
    cfg_data_i <= '0;
    err_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    // shadow reset state
    window_len = 16'd60;
    req_limit  = 5'd10;
    client_cap = 7'd64;
    block_on   = 1'b1;
    tracked_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_config_extremes();
    test_random_phase(8,     4,  64,  1, 0,  12, 126);
    test_random_phase(20,    16, 6,   0, 47, 12, 126);
    test_random_phase(3,     1,  2,   1, 21, 6,  126);
    test_random_phase(1,     31, 127, 1, 47, 12, 126);
    test_random_phase(65535, 2,  64,  0, 0,  10, 40);
    test_random_phase(40,    10, 64,  1, 21, 80, 126);

    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/pcswl_pkg.sv
design/pcswl_time_unit.sv
design/per_client_sliding_window_limiter_unit.sv
bench/tb_top.sv
